// ===== design/plid_pkg.sv =====
// plid_pkg: shared types and constants for the positional list block
// request/result structs, status and command codes, entry store control
// no dependencies
package plid_pkg;

    // list depth and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = ((CNT_W > 5) ? CNT_W : 5) + 1;

    // fixed field widths
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int ECNT_W   = 5;
    localparam int STAT_W   = 2;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef logic signed [DATA_W-1:0] word_t;

    // one request
    typedef struct packed {
        logic               cmd;
        logic [POS_W-1:0]   position;
        word_t              value;
    } req_t;

    // one result
    typedef struct packed {
        word_t              removed_value;
        logic [STAT_W-1:0]  status;
        logic [ECNT_W-1:0]  entry_count;
    } rsp_t;

    // entry store access for one cycle
    typedef struct packed {
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        word_t              wr_data;
    } mem_ctl_t;

endpackage

// ===== design/plid_store.sv =====
// plid_store: entry storage, one write port and one registered read port
// depends on plid_pkg
module plid_store (
    input  logic               clk,
    input  plid_pkg::mem_ctl_t ctl,
    output plid_pkg::word_t    rd_data
);

    plid_pkg::word_t mem [plid_pkg::CAPACITY];
    plid_pkg::word_t rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/plid_seq.sv =====
// plid_seq: sequencer that checks a request and moves entries one at a time
// depends on plid_pkg; drives the entry store in plid_store
module plid_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  plid_pkg::req_t     req,
    input  logic               slot_free,
    output logic               res_valid,
    output plid_pkg::rsp_t     res,
    output plid_pkg::mem_ctl_t mem_ctl,
    input  plid_pkg::word_t    rd_data
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_INS_RD  = 7'b0000010,
        S_INS_WR  = 7'b0000100,
        S_DEL_CAP = 7'b0001000,
        S_DEL_RD  = 7'b0010000,
        S_DEL_WR  = 7'b0100000,
        S_OUT     = 7'b1000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [plid_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [plid_pkg::IDX_W-1:0]      ptr_reg, ptr_next;
    logic [plid_pkg::IDX_W-1:0]      idx_reg, idx_next;
    plid_pkg::word_t                 value_reg, value_next;
    plid_pkg::word_t                 removed_reg, removed_next;
    logic [plid_pkg::STAT_W-1:0]     status_reg, status_next;
    logic [plid_pkg::IDX_W-1:0]      req_idx;

    assign req_idx   = plid_pkg::IDX_W'(req.position - plid_pkg::POS_W'(1));
    assign req_stall = (state_reg != S_IDLE);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
        end
    end

    // request payload and result fields
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        value_reg   <= value_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        ptr_next          = ptr_reg;
        idx_next          = idx_reg;
        value_next        = value_reg;
        removed_next      = removed_reg;
        status_next       = status_reg;
        mem_ctl           = '0;
        res_valid         = 1'b0;
        res.removed_value = removed_reg;
        res.status        = status_reg;
        res.entry_count   = plid_pkg::ECNT_W'(count_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    removed_next = '0;
                    status_next  = plid_pkg::ST_DONE;
                    idx_next     = req_idx;
                    value_next   = req.value;
                    if (req.cmd == plid_pkg::CMD_INSERT)
                    begin
                        if (count_reg >= plid_pkg::CNT_W'(plid_pkg::CAPACITY))
                        begin
                            status_next = plid_pkg::ST_FULL;
                            state_next  = S_OUT;
                        end
                        else if (req.position == '0 ||
                                 plid_pkg::CMP_W'(req.position) >
                                 plid_pkg::CMP_W'(count_reg) + plid_pkg::CMP_W'(1))
                        begin
                            status_next = plid_pkg::ST_RANGE;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            ptr_next   = plid_pkg::IDX_W'(count_reg);
                            state_next = S_INS_RD;
                        end
                    end
                    else
                    begin
                        if (req.position == '0 ||
                            plid_pkg::CMP_W'(req.position) > plid_pkg::CMP_W'(count_reg))
                        begin
                            status_next = plid_pkg::ST_RANGE;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            mem_ctl.rd_en   = 1'b1;
                            mem_ctl.rd_addr = req_idx;
                            ptr_next        = req_idx;
                            state_next      = S_DEL_CAP;
                        end
                    end
                end
            end

            // insert: move entries back from the tail, then place the value
            S_INS_RD:
            begin
                if (ptr_reg == idx_reg)
                begin
                    mem_ctl.wr_en   = 1'b1;
                    mem_ctl.wr_addr = ptr_reg;
                    mem_ctl.wr_data = value_reg;
                    count_next      = count_reg + plid_pkg::CNT_W'(1);
                    state_next      = S_OUT;
                end
                else
                begin
                    mem_ctl.rd_en   = 1'b1;
                    mem_ctl.rd_addr = ptr_reg - plid_pkg::IDX_W'(1);
                    state_next      = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_addr = ptr_reg;
                mem_ctl.wr_data = rd_data;
                ptr_next        = ptr_reg - plid_pkg::IDX_W'(1);
                state_next      = S_INS_RD;
            end

            // delete: capture the removed entry, then pull later entries forward
            S_DEL_CAP:
            begin
                removed_next = rd_data;
                state_next   = S_DEL_RD;
            end

            S_DEL_RD:
            begin
                if (plid_pkg::CNT_W'(ptr_reg) + plid_pkg::CNT_W'(1) >= count_reg)
                begin
                    count_next = count_reg - plid_pkg::CNT_W'(1);
                    state_next = S_OUT;
                end
                else
                begin
                    mem_ctl.rd_en   = 1'b1;
                    mem_ctl.rd_addr = ptr_reg + plid_pkg::IDX_W'(1);
                    state_next      = S_DEL_WR;
                end
            end

            S_DEL_WR:
            begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_addr = ptr_reg;
                mem_ctl.wr_data = rd_data;
                ptr_next        = ptr_reg + plid_pkg::IDX_W'(1);
                state_next      = S_DEL_RD;
            end

            // hand the result over once the output register can take it
            S_OUT:
            begin
                res_valid = slot_free;
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= plid_pkg::CNT_W'(plid_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        (count_reg == $past(count_reg) + plid_pkg::CNT_W'(1) ||
         count_reg == $past(count_reg) - plid_pkg::CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_ins_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_RD || state_reg == S_INS_WR) |-> ptr_reg >= idx_reg)
        else $error("insert shift ran past the target position");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> state_reg != S_IDLE)
        else $error("accepted request produced no work");
`endif

endmodule

// ===== design/positional_list_insert_delete.sv =====
// positional_list_insert_delete: top level of the positional list block
// depends on plid_pkg, plid_store and plid_seq
//
// Keeps an ordered list of up to CAPACITY signed 32-bit entries addressed by
// 1-based position. A request (req) inserts a value at a position or deletes
// the entry at a position; each request gives exactly one result (rsp) with
// the removed value, a status code and the entry count after the operation.
// Both channels hand over an item when valid is high and stall is low.
// A bad request (range or full) goes straight to its result without
// touching the entry store. A good one moves m entries (at most
// CAPACITY-1), each by one read and one write of the entry store. One
// request is worked at a time; req_stall stays high from acceptance
// until the result has gone into the output register, so a new request
// is taken only after the last result has been handed over. The output
// register lets a new request in while a result still waits; if rsp_stall
// holds, the next result waits in the sequencer and further requests are
// held off.
// Reset clears the list (count zero) and the output valid; the entry
// store itself needs no clearing because entries beyond the count are
// never read.
module positional_list_insert_delete (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  plid_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output plid_pkg::rsp_t   rsp
);

    plid_pkg::mem_ctl_t mem_ctl;
    plid_pkg::word_t    rd_data;
    plid_pkg::rsp_t     res;
    logic               res_valid;
    logic               slot_free;
    logic               rsp_valid_reg, rsp_valid_next;
    plid_pkg::rsp_t     rsp_reg;

    plid_store u_store (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_data (rd_data)
    );

    plid_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_ctl   (mem_ctl),
        .rd_data   (rd_data)
    );

    // output register free when empty or being taken this cycle
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_valid)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!rsp_valid_reg || !rsp_stall))
        else $error("result written over a pending one");
`endif

endmodule
